// File: rtl/core/cbs_pkg.sv
`default_nettype none
package cbs_pkg;

	localparam int COEFFS_PER_POLY_DEFAULT = 256;
	localparam int COEFF_W = 12;
	localparam logic [COEFF_W-1:0] MODULUS_Q = 12'd3329;
	localparam logic [1:0] ETA_RESET = 2'd2;
	localparam logic [1:0] ETA_THREE = 2'd3;

	// two entry queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// one classified byte: up to two coefficients
	typedef struct packed {
		logic [COEFF_W-1:0] c0;
		logic               l0;
		logic [COEFF_W-1:0] c1;
		logic               l1;
		logic               two;
	} cbs_entry_t;

	// (x - y) mod q over one coefficient's bits, low half is x
	function automatic logic [COEFF_W-1:0] cbd_coeff(input logic [5:0] b, input logic e3);
		logic [1:0] x;
		logic [1:0] y;
		begin
			x = {1'b0, b[0]} + {1'b0, b[1]} + (e3 ? {1'b0, b[2]} : 2'd0);
			y = e3 ? ({1'b0, b[3]} + {1'b0, b[4]} + {1'b0, b[5]})
				: ({1'b0, b[2]} + {1'b0, b[3]});
			if (x >= y) begin
				cbd_coeff = {{(COEFF_W-2){1'b0}}, x - y};
			end else begin
				cbd_coeff = MODULUS_Q - {{(COEFF_W-2){1'b0}}, y - x};
			end
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/cbs_front.sv
`default_nettype none
module cbs_front #(
	parameter int COEFFS_PER_POLY = cbs_pkg::COEFFS_PER_POLY_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        eta,
	input  wire logic              in_valid,
	input  wire logic [7:0]        random_byte,
	input  wire logic              full,
	output logic                   push,
	output cbs_pkg::cbs_entry_t    entry
);

	localparam int IDX_W = $clog2(COEFFS_PER_POLY);
	localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(COEFFS_PER_POLY - 1);

	logic [1:0]       eta_q;
	logic [3:0]       bits_q;
	logic [2:0]       cnt_q;
	logic [IDX_W-1:0] idx_q;

	logic        e3;
	logic [11:0] buf_w;
	logic [3:0]  count;
	logic        two;
	logic        l0;
	logic        l1;
	logic        done;
	logic [3:0]  rem_bits;
	logic [3:0]  rem_count;

	assign push = in_valid && !full;
	assign e3   = (eta_q == cbs_pkg::ETA_THREE);

	always_comb begin
		buf_w = {8'd0, bits_q} | ({4'd0, random_byte} << cnt_q);
		count = {1'b0, cnt_q} + 4'd8;
		// eta 2 always has two; eta 3 needs twelve bits
		two = e3 ? (count >= 4'd12) : 1'b1;
		l0 = ({1'b0, idx_q} >= LAST_IDX);
		l1 = (({1'b0, idx_q} + 1'b1) >= LAST_IDX);
		done = l0 || (two && l1);
		if (e3) begin
			rem_bits  = two ? 4'd0 : buf_w[9:6];
			rem_count = two ? (count - 4'd12) : (count - 4'd6);
		end else begin
			rem_bits  = buf_w[11:8];
			rem_count = count - 4'd8;
		end
		entry.c0  = cbs_pkg::cbd_coeff(e3 ? buf_w[5:0] : {2'b00, buf_w[3:0]}, e3);
		entry.l0  = l0;
		entry.c1  = cbs_pkg::cbd_coeff(e3 ? buf_w[11:6] : {2'b00, buf_w[7:4]}, e3);
		entry.l1  = l1;
		entry.two = two && !l0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q  <= cbs_pkg::ETA_RESET;
			bits_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (cfg_valid) begin
			eta_q  <= eta;
			bits_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (push) begin
			if (done) begin
				bits_q <= '0;
				cnt_q  <= '0;
				idx_q  <= '0;
			end else begin
				bits_q <= rem_bits;
				cnt_q  <= rem_count[2:0];
				idx_q  <= idx_q + (two ? IDX_W'(2) : IDX_W'(1));
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/cbs_queue.sv
`default_nettype none
module cbs_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire cbs_pkg::cbs_entry_t  wr_entry,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      not_empty,
	output cbs_pkg::cbs_entry_t       rd_entry
);

	cbs_pkg::cbs_entry_t               slot_q [cbs_pkg::QUEUE_DEPTH];
	logic [cbs_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [cbs_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [cbs_pkg::QCNT_W-1:0]        cnt_q;

	assign full      = (cnt_q == cbs_pkg::QCNT_W'(cbs_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/cbs_back.sv
`default_nettype none
module cbs_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire cbs_pkg::cbs_entry_t          q_entry,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [cbs_pkg::COEFF_W-1:0]       coefficient,
	output logic                              last_coefficient
);

	logic                          out_valid_q;
	logic [cbs_pkg::COEFF_W-1:0]   coeff_q;
	logic                          last_q;
	logic                          second_valid_q;
	logic [cbs_pkg::COEFF_W-1:0]   second_coeff_q;
	logic                          second_last_q;
	logic                          load;

	assign load             = !out_valid_q || !out_stall;
	assign pop              = load && !second_valid_q && q_valid;
	assign out_valid        = out_valid_q;
	assign coefficient      = coeff_q;
	assign last_coefficient = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (load) begin
			if (second_valid_q) begin
				out_valid_q    <= 1'b1;
				second_valid_q <= 1'b0;
			end else begin
				out_valid_q    <= q_valid;
				second_valid_q <= q_valid && q_entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_valid_q) begin
				coeff_q <= second_coeff_q;
				last_q  <= second_last_q;
			end else if (q_valid) begin
				coeff_q        <= q_entry.c0;
				last_q         <= q_entry.l0;
				second_coeff_q <= q_entry.c1;
				second_last_q  <= q_entry.l1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/centered_binomial_sampler.sv
`default_nettype none
// path: the first coefficient of a byte is written to a queue slot, then loaded into the
//   output register and presented from there, where out_stall can hold it
// throughput: one byte per cycle at the input while the queue has room; the single result port gives
//   one coefficient per cycle while out_stall is low, so eta 2 gives two per byte, eta 3 four per three bytes
// reset: asynchronous, active low; eta returns to 2, bit buffer, index and queue clear
// an eta write also clears bit buffer and index, starting a new polynomial
module centered_binomial_sampler #(
	parameter int COEFFS_PER_POLY = cbs_pkg::COEFFS_PER_POLY_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// eta register write
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [1:0]                   eta,
	// byte requests
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   random_byte,
	// coefficient requests
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [cbs_pkg::COEFF_W-1:0]       coefficient,
	output logic                              last_coefficient
);

	cbs_pkg::cbs_entry_t front_entry;
	cbs_pkg::cbs_entry_t queue_entry;
	logic                push;
	logic                pop;
	logic                full;
	logic                not_empty;

	// writes must arrive only while idle; the block does not enforce this, and the register is always ready
	assign cfg_ready = 1'b1;
	// front stalls only when the queue has no room
	assign in_stall  = full;

	// front: bit buffer, index and coefficient arithmetic, one byte per cycle while the queue has room
	cbs_front #(
		.COEFFS_PER_POLY(COEFFS_PER_POLY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.eta         (eta),
		.in_valid    (in_valid),
		.random_byte (random_byte),
		.full        (full),
		.push        (push),
		.entry       (front_entry)
	);

	// short queue decoupling the byte side from the coefficient side
	cbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (front_entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_entry  (queue_entry)
	);

	// back: splits each entry into one or two coefficient requests
	cbs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (not_empty),
		.q_entry          (queue_entry),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient)
	);

endmodule
`default_nettype wire

// File: sim/centered_binomial_sampler_test.sv
`default_nettype none
module centered_binomial_sampler_test;

	// polynomial length, left at the block's default
	localparam int POLY_LEN = cbs_pkg::COEFFS_PER_POLY_DEFAULT;
	// settle cycles after the last coefficient before touching eta
	localparam int SETTLE_CYCLES = 8;

	// one expected coefficient request
	typedef struct {
		logic [cbs_pkg::COEFF_W-1:0] value;
		logic                        is_last;
	} coeff_exp_t;

	// tracks the bit stream exactly as the sampler should see it and holds
	// the coefficients still owed by the block, oldest first
	class cbd_scoreboard;
		logic [1:0]   eta_sel;
		logic [3:0]   spare_bits;
		int unsigned  spare_cnt;
		int unsigned  coeff_idx;
		coeff_exp_t   owed_coeffs[$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  polys_done;

		function new();
			eta_sel = cbs_pkg::ETA_RESET;
			restart_poly();
			errors = 0;
			checked = 0;
			polys_done = 0;
		endfunction

		function void restart_poly();
			spare_bits = '0;
			spare_cnt = 0;
			coeff_idx = 0;
		endfunction

		// any eta write starts a new polynomial, same value or not
		function void write_eta(logic [1:0] v);
			eta_sel = v;
			restart_poly();
		endfunction

		// an accepted byte request: work out the one or two coefficients it gives
		function void note_byte(logic [7:0] b);
			int unsigned e;
			int unsigned width;
			int unsigned cnt;
			int unsigned produced;
			int unsigned x;
			int unsigned y;
			logic [15:0] bits;
			coeff_exp_t item;
			e = (eta_sel == cbs_pkg::ETA_THREE) ? 3 : 2;
			width = 2 * e;
			bits = 16'(spare_bits) | (16'(b) << spare_cnt);
			cnt = spare_cnt + 8;
			produced = 0;
			while (cnt >= width && produced < 2) begin
				x = 0;
				y = 0;
				for (int i = 0; i < e; i++) begin
					x += bits[i];
					y += bits[e + i];
				end
				item.value = (x >= y) ? cbs_pkg::COEFF_W'(x - y)
					: cbs_pkg::MODULUS_Q - cbs_pkg::COEFF_W'(y - x);
				item.is_last = (coeff_idx >= POLY_LEN - 1);
				owed_coeffs.push_back(item);
				produced++;
				bits = bits >> width;
				cnt -= width;
				if (item.is_last) begin
					// rest of the byte is dropped with the finished polynomial
					restart_poly();
					return;
				end
				coeff_idx++;
			end
			spare_bits = bits[3:0];
			spare_cnt = cnt;
		endfunction

		// an accepted coefficient request against the oldest one owed
		function void check_coeff(logic [cbs_pkg::COEFF_W-1:0] c, logic l);
			coeff_exp_t want;
			if (owed_coeffs.size() == 0) begin
				$display("%0t: unexpected coefficient %0d last %0b", $time, c, l);
				errors++;
				return;
			end
			want = owed_coeffs.pop_front();
			checked++;
			if (c !== want.value) begin
				$display("%0t: coefficient mismatch: expected %0d, got %0d",
					$time, want.value, c);
				errors++;
			end
			if (l !== want.is_last) begin
				$display("%0t: last_coefficient mismatch: expected %0b, got %0b",
					$time, want.is_last, l);
				errors++;
			end
			if (want.is_last) begin
				polys_done++;
			end
		endfunction

		function int unsigned pending();
			return owed_coeffs.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [1:0]                  eta_wdata = cbs_pkg::ETA_RESET;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  random_byte = 8'h00;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [cbs_pkg::COEFF_W-1:0] coefficient;
	logic                        last_coefficient;

	// no idling on either side while set
	logic               calm = 1'b0;
	int unsigned        bytes_sent = 0;

	cbd_scoreboard sb = new();

	always #1 clk = ~clk;

	centered_binomial_sampler #(
		.COEFFS_PER_POLY(POLY_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.eta(eta_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.random_byte(random_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.coefficient(coefficient),
		.last_coefficient(last_coefficient)
	);

	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	// one byte request: optional gap, then hold until taken
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		random_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic drop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait for every owed coefficient, then SETTLE_CYCLES more for the pipe to empty
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// eta write on the config channel, only once the sampler is idle
	task automatic write_eta(input logic [1:0] v);
		drop_input();
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		eta_wdata <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_eta(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly random bytes, with all-zero and all-one bytes mixed in
	function automatic logic [7:0] draw_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// receiver: random stall per coefficient request, sometimes none at all
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// every taken coefficient request goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_coeff(coefficient, last_coefficient);
		end
	end

	// eta settings for the random phases: repeats of the same value, both
	// legal values and both out of range codes
	int phase_eta[7] = '{3, 3, 2, 0, 1, 2, 3};

	initial begin
		logic [7:0] eta2_bytes[12];
		logic [7:0] eta3_bytes[12];
		int unsigned phase_len;
		eta2_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0,
			8'h33, 8'hCC, 8'h01, 8'h80, 8'h03, 8'hC0};
		eta3_bytes = '{8'h00, 8'hFF, 8'h07, 8'h38, 8'hC0, 8'h3F,
			8'h1C, 8'hE3, 8'h55, 8'hAA, 8'h00, 8'hFF};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset eta of 2, extremes of x and y in each half
		foreach (eta2_bytes[i]) begin
			send_byte(eta2_bytes[i]);
		end
		// directed: eta 3, where coefficients straddle byte edges
		write_eta(cbs_pkg::ETA_THREE);
		foreach (eta3_bytes[i]) begin
			send_byte(eta3_bytes[i]);
		end

		// random phases long enough to finish a whole polynomial at eta 2, not always at eta 3; every third
		// phase runs flat out with no idling on either side
		foreach (phase_eta[p]) begin
			write_eta(2'(phase_eta[p]));
			calm = (p % 3 == 1);
			phase_len = $urandom_range(180, 260);
			for (int n = 0; n < phase_len; n++) begin
				if (p == 2 && n == 100) begin
					// sender holds off until the sampler has caught up
					drop_input();
					while (sb.pending() != 0) @(posedge clk);
				end
				send_byte(draw_byte());
			end
		end

		drop_input();
		drain();
		$display("covered %0d byte requests and %0d coefficients over eta codes 0 to 3,",
			bytes_sent, sb.checked);
		$display("%0d polynomials ran to their last coefficient", sb.polys_done);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("centered_binomial_sampler test passed");
		end else begin
			$display("centered_binomial_sampler test failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("centered_binomial_sampler test failed");
		$finish;
	end

endmodule
`default_nettype wire
